// ===== src/lobm_pkg.sv =====
// lobm_pkg: shared types, codes and sizes for the order book matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
	localparam int BOOK_DEPTH = 32;
	localparam int SLOT_W = $clog2(BOOK_DEPTH);
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

	localparam logic [2:0] REQ_LIMIT_BUY   = 3'd0;
	localparam logic [2:0] REQ_LIMIT_SELL  = 3'd1;
	localparam logic [2:0] REQ_MARKET_BUY  = 3'd2;
	localparam logic [2:0] REQ_MARKET_SELL = 3'd3;
	localparam logic [2:0] REQ_CANCEL_BUY  = 3'd4;
	localparam logic [2:0] REQ_CANCEL_SELL = 3'd5;

	localparam logic [2:0] ST_FILLED    = 3'd0;
	localparam logic [2:0] ST_RESTED    = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_BOOK_FULL = 3'd6;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic [1:0] OP_CLR = 2'd0;
	localparam logic [1:0] OP_QTY = 2'd1;
	localparam logic [1:0] OP_NEW = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [30:0] order_id;
		logic [31:0] price;
		logic [30:0] quantity;
		logic [47:0] arrival_time;
	} req_t;

	typedef struct packed {
		logic        is_status;
		logic [30:0] counter_order_id;
		logic [31:0] trade_price;
		logic [30:0] trade_quantity;
		logic [2:0]  status;
		logic [30:0] remaining_quantity;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [30:0] id;
		logic [31:0] price;
		logic [30:0] qty;
		logic [47:0] time_stamp;
	} entry_t;

	// travels down the row: best entry so far, first id match, first free slot
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		entry_t            ent;
		logic              mfound;
		logic [SLOT_W-1:0] mslot;
		logic              ffound;
		logic [SLOT_W-1:0] fslot;
	} tok_t;

	typedef struct packed {
		logic        side;
		logic [30:0] match_id;
	} sweep_t;

	typedef struct packed {
		logic              en;
		logic              side;
		logic [1:0]        op;
		logic [SLOT_W-1:0] slot;
		entry_t            ent;
	} wr_t;
endpackage
`default_nettype wire

// ===== src/lobm_cell.sv =====
// lobm_cell: one book slot for each side; ranks itself against the passing token.
// Depends on lobm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lobm_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lobm_pkg::SLOT_W-1:0] idx,
	input  wire lobm_pkg::sweep_t          sweep,
	input  wire lobm_pkg::wr_t             wr,
	input  wire lobm_pkg::tok_t            tok_in,
	output lobm_pkg::tok_t                 tok_out
);
	logic             vld_q [2];
	lobm_pkg::entry_t ent_q [2];
	lobm_pkg::entry_t own;
	logic             own_v;
	logic             better;
	lobm_pkg::tok_t   tok_d;

	assign own   = ent_q[sweep.side];
	assign own_v = vld_q[sweep.side];

	always_comb begin
		if (own.price != tok_in.ent.price)
			better = (sweep.side == lobm_pkg::SIDE_SELL) ? (own.price < tok_in.ent.price)
			                                             : (own.price > tok_in.ent.price);
		else if (own.qty != tok_in.ent.qty)
			better = own.qty > tok_in.ent.qty;
		else if (own.time_stamp != tok_in.ent.time_stamp)
			better = own.time_stamp < tok_in.ent.time_stamp;
		else
			better = own.id < tok_in.ent.id;
	end

	always_comb begin
		tok_d = tok_in;
		// strict win only, so a tie keeps the lower slot
		if (own_v && (!tok_in.found || better)) begin
			tok_d.found = 1'b1;
			tok_d.slot  = idx;
			tok_d.ent   = own;
		end
		if (own_v && own.id == sweep.match_id && !tok_in.mfound) begin
			tok_d.mfound = 1'b1;
			tok_d.mslot  = idx;
		end
		if (!own_v && !tok_in.ffound) begin
			tok_d.ffound = 1'b1;
			tok_d.fslot  = idx;
		end
	end

	always_ff @(posedge clk) begin
		tok_out <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
			vld_q[1] <= 1'b0;
		end else if (wr.en && wr.slot == idx) begin
			unique case (wr.op)
				lobm_pkg::OP_CLR: vld_q[wr.side] <= 1'b0;
				lobm_pkg::OP_NEW: vld_q[wr.side] <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == idx) begin
			unique case (wr.op)
				lobm_pkg::OP_QTY: ent_q[wr.side].qty <= wr.ent.qty;
				lobm_pkg::OP_NEW: ent_q[wr.side] <= wr.ent;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/limit_order_book_matcher_core.sv =====
// One search is a check state, a sweep of the cell row and a decision state.
// A limit or market request runs one search per fill, plus one that stops short when no entry
// crosses or the book side is empty; a limit request with quantity left adds a resting check.
// A cancel is a sweep and a decision before its status is registered; an output stall holds it back.
// One request in work at a time, taken the cycle after the previous status is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset clears all valid bits at once; entry payloads are not reset.
// Depends on lobm_pkg and lobm_cell.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lobm_pkg::req_t in_req,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lobm_pkg::res_t     out_res
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SWEEP  = 3'd2;
	localparam logic [2:0] S_MATCH  = 3'd3;
	localparam logic [2:0] S_REST   = 3'd4;
	localparam logic [2:0] S_CANCEL = 3'd5;
	localparam logic [2:0] S_FINAL  = 3'd6;

	localparam int BOOK_DEPTH_P1 = lobm_pkg::BOOK_DEPTH + 1;

	logic [2:0]                  state_q, dec_q;
	logic [lobm_pkg::CNT_W-1:0]  cnt_q, nfill_q;
	logic                        stop_q, is_buy_q, is_limit_q;
	logic [30:0]                 rem_q;
	logic [2:0]                  st_q;
	lobm_pkg::req_t              req_q;
	lobm_pkg::sweep_t            sweep_q;
	lobm_pkg::wr_t               wr;
	lobm_pkg::tok_t              tok [BOOK_DEPTH_P1];
	lobm_pkg::tok_t              tail;
	lobm_pkg::res_t              res_q;
	logic                        ov_q, out_free, crosses, res_load;
	logic [30:0]                 tq;

	// the cell row: token enters empty at slot 0, leaves after the last slot
	assign tok[0] = '0;
	for (genvar i = 0; i < lobm_pkg::BOOK_DEPTH; i++) begin : g_cell
		lobm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (lobm_pkg::SLOT_W'(i)),
			.sweep   (sweep_q),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end
	assign tail = tok[lobm_pkg::BOOK_DEPTH];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_res   = res_q;
	assign out_free  = !ov_q || out_ready;

	assign crosses = is_buy_q ? (tail.ent.price <= req_q.price) : (tail.ent.price >= req_q.price);
	assign tq      = (rem_q < tail.ent.qty) ? rem_q : tail.ent.qty;

	// a fill or the status record goes into the output register this cycle
	assign res_load = out_free && (state_q == S_FINAL ||
	                  (state_q == S_MATCH && tail.found && (!is_limit_q || crosses)));

	// book writes, decided in the cycle after a sweep completes
	always_comb begin
		wr      = '0;
		wr.side = sweep_q.side;
		unique case (state_q)
			S_MATCH: begin
				if (tail.found && (!is_limit_q || crosses) && out_free) begin
					wr.en      = 1'b1;
					wr.slot    = tail.slot;
					wr.ent.qty = tail.ent.qty - tq;
					wr.op      = (tail.ent.qty == tq) ? lobm_pkg::OP_CLR : lobm_pkg::OP_QTY;
				end
			end
			S_REST: begin
				wr.en             = !tail.mfound && tail.ffound;
				wr.op             = lobm_pkg::OP_NEW;
				wr.slot           = tail.fslot;
				wr.ent.id         = req_q.order_id;
				wr.ent.price      = req_q.price;
				wr.ent.qty        = rem_q;
				wr.ent.time_stamp = req_q.arrival_time;
			end
			S_CANCEL: begin
				wr.en   = tail.mfound;
				wr.op   = lobm_pkg::OP_CLR;
				wr.slot = tail.mslot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dec_q   <= S_IDLE;
			cnt_q   <= '0;
			nfill_q <= '0;
			stop_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (res_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						nfill_q <= '0;
						stop_q  <= 1'b0;
						cnt_q   <= '0;
						if (in_req.req_type == lobm_pkg::REQ_CANCEL_BUY ||
						    in_req.req_type == lobm_pkg::REQ_CANCEL_SELL) begin
							state_q <= S_SWEEP;
							dec_q   <= S_CANCEL;
						end else if (in_req.req_type <= lobm_pkg::REQ_MARKET_SELL) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					cnt_q <= '0;
					if (rem_q == '0 || stop_q ||
					    nfill_q == lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH)) begin
						if (rem_q == '0 || !is_limit_q)
							state_q <= S_FINAL;
						else begin
							state_q <= S_SWEEP;
							dec_q   <= S_REST;
						end
					end else begin
						state_q <= S_SWEEP;
						dec_q   <= S_MATCH;
					end
				end
				S_SWEEP: begin
					if (cnt_q == lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH - 1))
						state_q <= dec_q;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_MATCH: begin
					if (!tail.found || (is_limit_q && !crosses)) begin
						stop_q  <= 1'b1;
						state_q <= S_CHECK;
					end else if (out_free) begin
						nfill_q <= nfill_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_REST, S_CANCEL: state_q <= S_FINAL;
				S_FINAL: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request context, result register and side selection
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q      <= in_req;
				rem_q      <= in_req.quantity;
				is_buy_q   <= (in_req.req_type == lobm_pkg::REQ_LIMIT_BUY ||
				               in_req.req_type == lobm_pkg::REQ_MARKET_BUY);
				is_limit_q <= (in_req.req_type == lobm_pkg::REQ_LIMIT_BUY ||
				               in_req.req_type == lobm_pkg::REQ_LIMIT_SELL);
				sweep_q.match_id <= in_req.order_id;
				sweep_q.side     <= (in_req.req_type == lobm_pkg::REQ_CANCEL_SELL);
			end
			S_CHECK: begin
				if (rem_q == '0)
					st_q <= lobm_pkg::ST_FILLED;
				else
					st_q <= lobm_pkg::ST_DROPPED;
				// resting goes on own side, matching against the opposite one
				if (rem_q == '0 || stop_q || nfill_q == lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH))
					sweep_q.side <= is_buy_q ? lobm_pkg::SIDE_BUY : lobm_pkg::SIDE_SELL;
				else
					sweep_q.side <= is_buy_q ? lobm_pkg::SIDE_SELL : lobm_pkg::SIDE_BUY;
			end
			S_MATCH: begin
				if (tail.found && (!is_limit_q || crosses) && out_free) begin
					rem_q <= rem_q - tq;
					res_q <= '{is_status: 1'b0, counter_order_id: tail.ent.id,
					           trade_price: tail.ent.price, trade_quantity: tq,
					           status: lobm_pkg::ST_FILLED, remaining_quantity: rem_q - tq,
					           last: 1'b0};
				end
			end
			S_REST: begin
				if (tail.mfound)
					st_q <= lobm_pkg::ST_DUPLICATE;
				else if (!tail.ffound)
					st_q <= lobm_pkg::ST_BOOK_FULL;
				else
					st_q <= lobm_pkg::ST_RESTED;
			end
			S_CANCEL: begin
				rem_q <= '0;
				st_q  <= tail.mfound ? lobm_pkg::ST_CANCELLED : lobm_pkg::ST_NOT_FOUND;
			end
			S_FINAL: begin
				if (out_free)
					res_q <= '{is_status: 1'b1, counter_order_id: '0, trade_price: '0,
					           trade_quantity: '0, status: st_q,
					           remaining_quantity: rem_q, last: 1'b1};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/lobm_checker.sv =====
// lobm_checker: port-level checks on the matcher, bound to the top level.
// Depends on lobm_pkg and limit_order_book_matcher_core.
`timescale 1ns / 1ps
`default_nettype none
module lobm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire lobm_pkg::req_t in_req,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire lobm_pkg::res_t out_res
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_res))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req.req_type <= lobm_pkg::REQ_CANCEL_SELL |=> !in_ready)
		else $error("new request taken while one is in work");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.last |-> out_res.is_status)
		else $error("last flag on a fill record");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_res.is_status |-> out_res.status == lobm_pkg::ST_FILLED && !out_res.last)
		else $error("malformed fill record");
endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (.*);
`default_nettype wire
